// ===== rtl/core/bnms_pkg.sv =====
`timescale 1ns / 1ps

package bnms_pkg;

    // Capacity of one set and derived widths
    localparam int BOX_MAX = 32;
    localparam int IDX_W   = $clog2(BOX_MAX);
    localparam int CNT_W   = $clog2(BOX_MAX + 1);

    // Field widths
    localparam int COORD_W = 12;
    localparam int SIZE_W  = 11;
    localparam int THR_W   = 16;

    // Arithmetic widths
    localparam int EDGE_W  = COORD_W + 1;
    localparam int AREA_W  = 2 * SIZE_W;
    localparam int UNION_W = AREA_W + 1;
    localparam int PROD_W  = THR_W + UNION_W;

    // Threshold after reset, about 0.1 in Q0.16
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(6554);

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic        [SIZE_W-1:0]  width;
        logic        [SIZE_W-1:0]  height;
    } box_t;

    localparam int BOX_W = $bits(box_t);

    // Controller to datapath
    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             sel_mode;
        logic             sel_start;
        logic             emit;
    } nms_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             pipe_busy;
        logic             out_free;
        logic             rest_empty;
    } nms_stat_t;

endpackage

// ===== rtl/core/bnms_ram.sv =====
`timescale 1ns / 1ps

module bnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/bnms_ctrl.sv =====
`timescale 1ns / 1ps

module bnms_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 box_valid,
    input  logic                 last_box,
    output logic                 box_stall,
    input  bnms_pkg::nms_stat_t  stat,
    output bnms_pkg::nms_cmd_t   cmd
);

    localparam logic [2:0] ST_LOAD     = 3'd0;
    localparam logic [2:0] ST_SEL      = 3'd1;
    localparam logic [2:0] ST_SEL_WAIT = 3'd2;
    localparam logic [2:0] ST_SUP      = 3'd3;
    localparam logic [2:0] ST_SUP_WAIT = 3'd4;
    localparam logic [2:0] ST_EMIT     = 3'd5;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [bnms_pkg::CNT_W-1:0] scan_reg;
    logic [bnms_pkg::CNT_W-1:0] scan_next;
    logic                       scan_last;

    assign scan_last = (scan_reg == (stat.count - bnms_pkg::CNT_W'(1)));
    assign box_stall = (state_reg != ST_LOAD);

    // Sequence load, select, suppress and emit
    always_comb
    begin
        state_next    = state_reg;
        scan_next     = scan_reg;
        cmd           = '0;
        cmd.rd_addr   = scan_reg[bnms_pkg::IDX_W-1:0];
        case (state_reg)
            ST_LOAD:
            begin
                cmd.load = box_valid;
                if (box_valid && last_box)
                begin
                    state_next = ST_SEL;
                    scan_next  = '0;
                end
            end
            ST_SEL:
            begin
                cmd.rd_en     = 1'b1;
                cmd.sel_mode  = 1'b1;
                cmd.sel_start = (scan_reg == '0);
                if (scan_last)
                begin
                    state_next = ST_SEL_WAIT;
                    scan_next  = '0;
                end
                else
                begin
                    scan_next = scan_reg + bnms_pkg::CNT_W'(1);
                end
            end
            ST_SEL_WAIT:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_SUP;
                end
            end
            ST_SUP:
            begin
                cmd.rd_en = 1'b1;
                if (scan_last)
                begin
                    state_next = ST_SUP_WAIT;
                    scan_next  = '0;
                end
                else
                begin
                    scan_next = scan_reg + bnms_pkg::CNT_W'(1);
                end
            end
            ST_SUP_WAIT:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stat.rest_empty ? ST_LOAD : ST_SEL;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
                scan_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            scan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
        end
    end

endmodule

// ===== rtl/core/bnms_datapath.sv =====
`timescale 1ns / 1ps

module bnms_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bnms_pkg::nms_cmd_t                   cmd,
    output bnms_pkg::nms_stat_t                  stat,
    input  logic                                 cfg_wr,
    input  logic        [bnms_pkg::THR_W-1:0]    cfg_data,
    input  logic signed [bnms_pkg::COORD_W-1:0]  box_left,
    input  logic signed [bnms_pkg::COORD_W-1:0]  box_top,
    input  logic        [bnms_pkg::SIZE_W-1:0]   box_width,
    input  logic        [bnms_pkg::SIZE_W-1:0]   box_height,
    output logic                                 kept_valid,
    input  logic                                 kept_stall,
    output logic signed [bnms_pkg::COORD_W-1:0]  kept_left,
    output logic signed [bnms_pkg::COORD_W-1:0]  kept_top,
    output logic        [bnms_pkg::SIZE_W-1:0]   kept_width,
    output logic        [bnms_pkg::SIZE_W-1:0]   kept_height,
    output logic                                 last_kept,
    output logic                                 overflowed
);

    // Overlap of two 1-D extents, zero when they only touch or are apart
    function automatic logic [bnms_pkg::SIZE_W-1:0] overlap(
        input logic signed [bnms_pkg::COORD_W-1:0] pa,
        input logic        [bnms_pkg::SIZE_W-1:0]  sa,
        input logic signed [bnms_pkg::COORD_W-1:0] pb,
        input logic        [bnms_pkg::SIZE_W-1:0]  sb
    );
        logic signed [bnms_pkg::EDGE_W-1:0] a0;
        logic signed [bnms_pkg::EDGE_W-1:0] b0;
        logic signed [bnms_pkg::EDGE_W-1:0] a1;
        logic signed [bnms_pkg::EDGE_W-1:0] b1;
        logic signed [bnms_pkg::EDGE_W-1:0] lo;
        logic signed [bnms_pkg::EDGE_W-1:0] hi;
        logic signed [bnms_pkg::EDGE_W:0]   span;
        a0   = $signed({pa[bnms_pkg::COORD_W-1], pa});
        b0   = $signed({pb[bnms_pkg::COORD_W-1], pb});
        a1   = a0 + $signed({2'b00, sa});
        b1   = b0 + $signed({2'b00, sb});
        lo   = (a0 > b0) ? a0 : b0;
        hi   = (a1 < b1) ? a1 : b1;
        span = $signed({hi[bnms_pkg::EDGE_W-1], hi}) - $signed({lo[bnms_pkg::EDGE_W-1], lo});
        return (span > 0) ? span[bnms_pkg::SIZE_W-1:0] : '0;
    endfunction

    logic [bnms_pkg::THR_W-1:0]   thr_reg;
    logic [bnms_pkg::CNT_W-1:0]   count_reg;
    logic [bnms_pkg::CNT_W-1:0]   count_next;
    logic                         overflow_reg;
    logic                         overflow_next;
    logic [bnms_pkg::BOX_MAX-1:0] alive_reg;
    logic [bnms_pkg::BOX_MAX-1:0] alive_next;
    logic [bnms_pkg::BOX_MAX-1:0] best_onehot;
    logic                         has_room;
    bnms_pkg::box_t               in_box;
    bnms_pkg::box_t               rd_box;

    // Read pipeline stage
    logic                         p1_valid_reg;
    logic                         p1_sel_reg;
    logic [bnms_pkg::IDX_W-1:0]   p1_idx_reg;

    // Selection state
    logic                         found_reg;
    bnms_pkg::box_t               best_box_reg;
    logic [bnms_pkg::IDX_W-1:0]   best_idx_reg;
    logic signed [bnms_pkg::EDGE_W-1:0] best_bottom_reg;
    logic signed [bnms_pkg::EDGE_W-1:0] cand_bottom;
    logic                         take;
    logic [bnms_pkg::AREA_W-1:0]  ka_reg;

    // Overlap pipeline stages
    logic                         a_valid_reg;
    logic [bnms_pkg::IDX_W-1:0]   a_idx_reg;
    logic [bnms_pkg::SIZE_W-1:0]  a_dx_reg;
    logic [bnms_pkg::SIZE_W-1:0]  a_dy_reg;
    logic [bnms_pkg::SIZE_W-1:0]  a_w_reg;
    logic [bnms_pkg::SIZE_W-1:0]  a_h_reg;
    logic                         b_valid_reg;
    logic [bnms_pkg::IDX_W-1:0]   b_idx_reg;
    logic [bnms_pkg::AREA_W-1:0]  b_inter_reg;
    logic [bnms_pkg::AREA_W-1:0]  b_area_reg;
    logic                         c_valid_reg;
    logic [bnms_pkg::IDX_W-1:0]   c_idx_reg;
    logic [bnms_pkg::AREA_W-1:0]  c_inter_reg;
    logic [bnms_pkg::UNION_W-1:0] c_union_reg;
    logic [bnms_pkg::PROD_W-1:0]  lhs;
    logic [bnms_pkg::PROD_W-1:0]  rhs;
    logic                         hit;

    // Output register
    logic                         kept_valid_reg;
    bnms_pkg::box_t               kept_box_reg;
    logic                         last_kept_reg;
    logic                         overflowed_reg;

    assign in_box.left   = box_left;
    assign in_box.top    = box_top;
    assign in_box.width  = box_width;
    assign in_box.height = box_height;
    assign has_room      = (count_reg < bnms_pkg::CNT_W'(bnms_pkg::BOX_MAX));

    bnms_ram #(
        .WIDTH (bnms_pkg::BOX_W),
        .DEPTH (bnms_pkg::BOX_MAX)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.load && has_room),
        .wr_addr (count_reg[bnms_pkg::IDX_W-1:0]),
        .wr_data (in_box),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_box)
    );

    // Pick the live box with the greatest bottom edge seen so far, later wins ties
    assign cand_bottom = $signed({rd_box.top[bnms_pkg::COORD_W-1], rd_box.top})
                       + $signed({2'b00, rd_box.height});
    assign take = p1_valid_reg && p1_sel_reg && alive_reg[p1_idx_reg]
               && (!found_reg || (cand_bottom >= best_bottom_reg));

    assign best_onehot = {{(bnms_pkg::BOX_MAX-1){1'b0}}, 1'b1} << best_idx_reg;

    // Compare intersection against threshold times union
    assign lhs = {1'b0, c_inter_reg, {bnms_pkg::THR_W{1'b0}}};
    assign rhs = bnms_pkg::PROD_W'(thr_reg) * bnms_pkg::PROD_W'(c_union_reg);
    assign hit = c_valid_reg && (lhs > rhs);

    // Update set bookkeeping
    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        alive_next    = alive_reg;
        if (cmd.load)
        begin
            if (has_room)
            begin
                alive_next[count_reg[bnms_pkg::IDX_W-1:0]] = 1'b1;
                count_next = count_reg + bnms_pkg::CNT_W'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
        if (hit)
        begin
            alive_next[c_idx_reg] = 1'b0;
        end
        if (cmd.emit)
        begin
            alive_next = alive_reg & ~best_onehot;
            if (stat.rest_empty)
            begin
                count_next    = '0;
                overflow_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.count      = count_reg;
        stat.pipe_busy  = p1_valid_reg || a_valid_reg || b_valid_reg || c_valid_reg;
        stat.out_free   = !kept_valid_reg || !kept_stall;
        stat.rest_empty = ((alive_reg & ~best_onehot) == '0);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= bnms_pkg::THR_RESET;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            alive_reg      <= '0;
            p1_valid_reg   <= 1'b0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            found_reg      <= 1'b0;
            kept_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                thr_reg <= cfg_data;
            end
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            alive_reg    <= alive_next;
            p1_valid_reg <= cmd.rd_en;
            a_valid_reg  <= p1_valid_reg && !p1_sel_reg;
            b_valid_reg  <= a_valid_reg;
            c_valid_reg  <= b_valid_reg;
            if (cmd.sel_start)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                kept_valid_reg <= 1'b1;
            end
            else if (!kept_stall)
            begin
                kept_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        p1_sel_reg <= cmd.sel_mode;
        p1_idx_reg <= cmd.rd_addr;
        if (take)
        begin
            best_box_reg    <= rd_box;
            best_idx_reg    <= p1_idx_reg;
            best_bottom_reg <= cand_bottom;
        end
        ka_reg      <= best_box_reg.width * best_box_reg.height;
        a_idx_reg   <= p1_idx_reg;
        a_dx_reg    <= overlap(best_box_reg.left, best_box_reg.width,
                               rd_box.left, rd_box.width);
        a_dy_reg    <= overlap(best_box_reg.top, best_box_reg.height,
                               rd_box.top, rd_box.height);
        a_w_reg     <= rd_box.width;
        a_h_reg     <= rd_box.height;
        b_idx_reg   <= a_idx_reg;
        b_inter_reg <= a_dx_reg * a_dy_reg;
        b_area_reg  <= a_w_reg * a_h_reg;
        c_idx_reg   <= b_idx_reg;
        c_inter_reg <= b_inter_reg;
        c_union_reg <= bnms_pkg::UNION_W'(ka_reg) + bnms_pkg::UNION_W'(b_area_reg)
                     - bnms_pkg::UNION_W'(b_inter_reg);
        if (cmd.emit)
        begin
            kept_box_reg   <= best_box_reg;
            last_kept_reg  <= stat.rest_empty;
            overflowed_reg <= overflow_reg;
        end
    end

    assign kept_valid  = kept_valid_reg;
    assign kept_left   = kept_box_reg.left;
    assign kept_top    = kept_box_reg.top;
    assign kept_width  = kept_box_reg.width;
    assign kept_height = kept_box_reg.height;
    assign last_kept   = last_kept_reg;
    assign overflowed  = overflowed_reg;

endmodule

// ===== rtl/core/box_non_maximum_suppression.sv =====
// Channel   Direction  Handshake             Payload
// box       in         box_valid/box_stall   box_left box_top box_width box_height last_box
// kept      out        kept_valid/kept_stall kept_left kept_top kept_width kept_height
//                                            last_kept overflowed
// cfg       in         cfg_valid/cfg_ready   cfg_data (overlap threshold, Q0.16)
//
// Loading takes one box per cycle while box_stall is low. A suppression round reads
// each stored box once to pick the best and lets the read stage drain, then reads each
// again through the overlap pipeline, drains it, emits; K kept boxes cost K rounds.
// Reset clears the set (count, live bits, overflow) and sets the threshold to 6554;
// the box store needs no clearing pass. box_stall is high from the last box until
// the last kept box is registered; a stalled kept transfer holds the next round's emit.
`timescale 1ns / 1ps

module box_non_maximum_suppression (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 box_valid,
    output logic                                 box_stall,
    input  logic signed [bnms_pkg::COORD_W-1:0]  box_left,
    input  logic signed [bnms_pkg::COORD_W-1:0]  box_top,
    input  logic        [bnms_pkg::SIZE_W-1:0]   box_width,
    input  logic        [bnms_pkg::SIZE_W-1:0]   box_height,
    input  logic                                 last_box,
    output logic                                 kept_valid,
    input  logic                                 kept_stall,
    output logic signed [bnms_pkg::COORD_W-1:0]  kept_left,
    output logic signed [bnms_pkg::COORD_W-1:0]  kept_top,
    output logic        [bnms_pkg::SIZE_W-1:0]   kept_width,
    output logic        [bnms_pkg::SIZE_W-1:0]   kept_height,
    output logic                                 last_kept,
    output logic                                 overflowed,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [bnms_pkg::THR_W-1:0]    cfg_data
);

    bnms_pkg::nms_cmd_t  cmd;
    bnms_pkg::nms_stat_t stat;

    // Take threshold writes at any time
    assign cfg_ready = 1'b1;

    bnms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .box_valid (box_valid),
        .last_box  (last_box),
        .box_stall (box_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bnms_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_width   (box_width),
        .box_height  (box_height),
        .kept_valid  (kept_valid),
        .kept_stall  (kept_stall),
        .kept_left   (kept_left),
        .kept_top    (kept_top),
        .kept_width  (kept_width),
        .kept_height (kept_height),
        .last_kept   (last_kept),
        .overflowed  (overflowed)
    );

endmodule

// ===== rtl/core/bnms_checker.sv =====
`timescale 1ns / 1ps

module bnms_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 box_valid,
    input logic                                 box_stall,
    input logic                                 last_box,
    input logic                                 kept_valid,
    input logic                                 kept_stall,
    input logic signed [bnms_pkg::COORD_W-1:0]  kept_left,
    input logic signed [bnms_pkg::COORD_W-1:0]  kept_top,
    input logic        [bnms_pkg::SIZE_W-1:0]   kept_width,
    input logic        [bnms_pkg::SIZE_W-1:0]   kept_height,
    input logic                                 last_kept,
    input logic                                 overflowed
);

    // Hold a stalled kept transfer
    a_kept_hold: assert property (@(posedge clk) disable iff (!rst_n)
        kept_valid && kept_stall |=> kept_valid && $stable(kept_left)
            && $stable(kept_top) && $stable(kept_width) && $stable(kept_height)
            && $stable(last_kept) && $stable(overflowed))
        else $error("kept payload changed while stalled");

    // Stop taking boxes once a set is closed
    a_set_closed: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && !box_stall && last_box |=> box_stall)
        else $error("box taken right after the last box of a set");

    // A set still being emitted keeps the box channel stalled
    a_set_busy: assert property (@(posedge clk) disable iff (!rst_n)
        kept_valid && !last_kept |-> box_stall)
        else $error("box channel open while a set is unfinished");

endmodule

bind box_non_maximum_suppression bnms_checker u_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // One kept box as it leaves the block
    typedef struct packed {
        bnms_pkg::box_t b;
        logic           last;
        logic           ovf;
    } kept_t;

    // One row of the directed stimulus
    typedef struct packed {
        bnms_pkg::box_t b;
        logic           last;
        logic           typed;
        kept_t          want;
    } stim_row_t;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE      = 100;
    localparam int PHASES      = 7;
    localparam int PHASE_BOXES = 45;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                box_valid = 1'b0;
    logic                                box_stall;
    logic signed [bnms_pkg::COORD_W-1:0] box_left = '0;
    logic signed [bnms_pkg::COORD_W-1:0] box_top = '0;
    logic        [bnms_pkg::SIZE_W-1:0]  box_width = '0;
    logic        [bnms_pkg::SIZE_W-1:0]  box_height = '0;
    logic                                last_box = 1'b0;
    logic                                kept_valid;
    logic                                kept_stall = 1'b1;
    logic signed [bnms_pkg::COORD_W-1:0] kept_left;
    logic signed [bnms_pkg::COORD_W-1:0] kept_top;
    logic        [bnms_pkg::SIZE_W-1:0]  kept_width;
    logic        [bnms_pkg::SIZE_W-1:0]  kept_height;
    logic                                last_kept;
    logic                                overflowed;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic        [bnms_pkg::THR_W-1:0]   cfg_data = '0;

    // Typed expectation that rides along with the box being offered
    logic  row_typed = 1'b0;
    kept_t row_expect = '0;

    // Predictor state
    bnms_pkg::box_t               held [bnms_pkg::BOX_MAX];
    logic [bnms_pkg::BOX_MAX-1:0] live = '0;
    int                           held_count = 0;
    logic                         dropped = 1'b0;
    logic [bnms_pkg::THR_W-1:0]   iou_thr = bnms_pkg::THR_RESET;

    kept_t     kept_expected[$];
    stim_row_t directed_rows[$];
    int        mismatches = 0;
    int        quiet = 0;
    bit        calm = 1'b0;

    box_non_maximum_suppression dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .box_valid   (box_valid),
        .box_stall   (box_stall),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_width   (box_width),
        .box_height  (box_height),
        .last_box    (last_box),
        .kept_valid  (kept_valid),
        .kept_stall  (kept_stall),
        .kept_left   (kept_left),
        .kept_top    (kept_top),
        .kept_width  (kept_width),
        .kept_height (kept_height),
        .last_kept   (last_kept),
        .overflowed  (overflowed),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the kept side at random, except in the calm phase
    always @(negedge clk)
    begin
        kept_stall <= !calm && ($urandom_range(0, 99) < 29);
    end

    function automatic longint box_area(bnms_pkg::box_t a);
        return longint'(a.width) * longint'(a.height);
    endfunction

    function automatic longint overlap_area(bnms_pkg::box_t a, bnms_pkg::box_t c);
        int x0;
        int y0;
        int x1;
        int y1;
        x0 = (int'(a.left) > int'(c.left)) ? int'(a.left) : int'(c.left);
        y0 = (int'(a.top) > int'(c.top)) ? int'(a.top) : int'(c.top);
        x1 = int'(a.left) + int'(a.width);
        if (int'(c.left) + int'(c.width) < x1)
            x1 = int'(c.left) + int'(c.width);
        y1 = int'(a.top) + int'(a.height);
        if (int'(c.top) + int'(c.height) < y1)
            y1 = int'(c.top) + int'(c.height);
        if (x1 <= x0 || y1 <= y0)
            return 0;
        return longint'(x1 - x0) * longint'(y1 - y0);
    endfunction

    // Store one box, or flag the set when it is full
    task automatic hold_box(bnms_pkg::box_t b);
        if (held_count < bnms_pkg::BOX_MAX)
        begin
            held[held_count] = b;
            live[held_count] = 1'b1;
            held_count++;
        end
        else
        begin
            dropped = 1'b1;
        end
    endtask

    // Run greedy suppression over the held set and queue the kept boxes
    task automatic close_set();
        int             i;
        int             best;
        int             bottom;
        int             best_bottom;
        bit             found;
        longint         ka;
        longint         inter;
        longint         uni;
        bnms_pkg::box_t k;
        kept_t          r;
        while (live != '0)
        begin
            found = 1'b0;
            best = 0;
            best_bottom = 0;
            for (i = 0; i < held_count; i++)
            begin
                if (live[i])
                begin
                    bottom = int'(held[i].top) + int'(held[i].height);
                    if (!found || bottom >= best_bottom)
                    begin
                        best = i;
                        best_bottom = bottom;
                        found = 1'b1;
                    end
                end
            end
            live[best] = 1'b0;
            k = held[best];
            r.b = k;
            r.last = 1'b0;
            r.ovf = dropped;
            kept_expected = {kept_expected, r};
            ka = box_area(k);
            // Drop every live box that overlaps the kept one too much
            for (i = 0; i < held_count; i++)
            begin
                if (live[i])
                begin
                    inter = overlap_area(k, held[i]);
                    uni = ka + box_area(held[i]) - inter;
                    if (inter * 65536 > longint'(iou_thr) * uni)
                        live[i] = 1'b0;
                end
            end
        end
        r = kept_expected.pop_back();
        r.last = 1'b1;
        kept_expected = {kept_expected, r};
        held_count = 0;
        live = '0;
        dropped = 1'b0;
    endtask

    // Check kept transfers, predict on box transfers, track the threshold
    always @(posedge clk)
    begin : scoreboard
        kept_t          got;
        kept_t          want;
        bnms_pkg::box_t in_box;
        if (kept_valid && !kept_stall)
        begin
            got.b.left = kept_left;
            got.b.top = kept_top;
            got.b.width = kept_width;
            got.b.height = kept_height;
            got.last = last_kept;
            got.ovf = overflowed;
            if (kept_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected kept box: left %0d top %0d width %0d height %0d",
                             got.b.left, got.b.top, got.b.width, got.b.height);
            end
            else
            begin
                want = kept_expected.pop_front();
                if (got.b.left !== want.b.left || got.b.top !== want.b.top
                    || got.b.width !== want.b.width || got.b.height !== want.b.height
                    || got.last !== want.last || got.ovf !== want.ovf)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"kept box mismatch: expected %0d %0d %0d %0d last %0b ",
                                  "ovf %0b, got %0d %0d %0d %0d last %0b ovf %0b"},
                                 want.b.left, want.b.top, want.b.width, want.b.height,
                                 want.last, want.ovf, got.b.left, got.b.top, got.b.width,
                                 got.b.height, got.last, got.ovf);
                end
            end
        end
        if (box_valid && !box_stall)
        begin
            in_box.left = box_left;
            in_box.top = box_top;
            in_box.width = box_width;
            in_box.height = box_height;
            hold_box(in_box);
            if (last_box)
            begin
                close_set();
                if (row_typed)
                    kept_expected[kept_expected.size() - 1] = row_expect;
            end
        end
        if (cfg_valid && cfg_ready)
            iou_thr = cfg_data;
        // End the run when nothing has moved for too long
        if ((kept_valid && !kept_stall) || (box_valid && !box_stall) || (cfg_valid && cfg_ready))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic void plain_row(int l, int t, int w, int h, bit lst);
        stim_row_t r;
        r.b.left = bnms_pkg::COORD_W'(l);
        r.b.top = bnms_pkg::COORD_W'(t);
        r.b.width = bnms_pkg::SIZE_W'(w);
        r.b.height = bnms_pkg::SIZE_W'(h);
        r.last = lst;
        r.typed = 1'b0;
        r.want = '0;
        directed_rows = {directed_rows, r};
    endfunction

    // Single-box set whose one kept box is typed in
    function automatic void alone_row(int l, int t, int w, int h,
                                      int el, int et, int ew, int eh, bit elast, bit eovf);
        stim_row_t r;
        r.b.left = bnms_pkg::COORD_W'(l);
        r.b.top = bnms_pkg::COORD_W'(t);
        r.b.width = bnms_pkg::SIZE_W'(w);
        r.b.height = bnms_pkg::SIZE_W'(h);
        r.last = 1'b1;
        r.typed = 1'b1;
        r.want.b.left = bnms_pkg::COORD_W'(el);
        r.want.b.top = bnms_pkg::COORD_W'(et);
        r.want.b.width = bnms_pkg::SIZE_W'(ew);
        r.want.b.height = bnms_pkg::SIZE_W'(eh);
        r.want.last = elast;
        r.want.ovf = eovf;
        directed_rows = {directed_rows, r};
    endfunction

    // Offer one box, with a random gap first, and hold it until the transfer
    task automatic send_box(bnms_pkg::box_t b, logic lst, logic typed, kept_t want);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 29)
        begin
            box_valid <= 1'b0;
            @(negedge clk);
        end
        box_valid <= 1'b1;
        box_left <= b.left;
        box_top <= b.top;
        box_width <= b.width;
        box_height <= b.height;
        last_box <= lst;
        row_typed <= typed;
        row_expect <= want;
        do
            @(posedge clk);
        while (box_stall);
    endtask

    // Send one set: mostly a cluster of overlapping boxes, some random noise
    task automatic send_set(int n);
        int             k;
        int             cx;
        int             cy;
        int             span;
        int             jit;
        bit             clustered;
        bnms_pkg::box_t b;
        clustered = ($urandom_range(0, 99) < 80);
        cx = $urandom_range(0, 3000) - 1500;
        cy = $urandom_range(0, 3000) - 1500;
        span = $urandom_range(4, 300);
        jit = $urandom_range(0, span / 2 + 1);
        for (k = 0; k < n; k++)
        begin
            if (clustered && $urandom_range(0, 99) >= 10)
            begin
                b.left = bnms_pkg::COORD_W'(cx + $urandom_range(0, 2 * jit) - jit);
                b.top = bnms_pkg::COORD_W'(cy + $urandom_range(0, 2 * jit) - jit);
                b.width = bnms_pkg::SIZE_W'(span + $urandom_range(0, jit));
                b.height = bnms_pkg::SIZE_W'(span + $urandom_range(0, jit));
                if ($urandom_range(0, 99) < 4)
                    b.width = '0;
            end
            else
            begin
                b.left = bnms_pkg::COORD_W'($urandom);
                b.top = bnms_pkg::COORD_W'($urandom);
                b.width = bnms_pkg::SIZE_W'($urandom);
                b.height = bnms_pkg::SIZE_W'($urandom);
            end
            send_box(b, k == n - 1, 1'b0, '0);
        end
    endtask

    // Write the overlap threshold while the block is idle
    task automatic write_threshold(logic [bnms_pkg::THR_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering boxes and let every expected kept box drain
    task automatic drain();
        @(negedge clk);
        box_valid <= 1'b0;
        while (kept_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int                         ph;
        int                         sent;
        int                         n;
        logic [bnms_pkg::THR_W-1:0] thr;

        // Directed sets at the reset threshold
        alone_row(-2048, -2048, 2047, 2047, -2048, -2048, 2047, 2047, 1'b1, 1'b0);
        alone_row(2047, 2047, 0, 0, 2047, 2047, 0, 0, 1'b1, 1'b0);
        alone_row(0, 0, 1, 1, 0, 0, 1, 1, 1'b1, 1'b0);
        alone_row(-1, -1, 1024, 1, -1, -1, 1024, 1, 1'b1, 1'b0);
        // identical boxes: the later one wins the tie, the other is dropped
        plain_row(100, 100, 50, 50, 1'b0);
        plain_row(100, 100, 50, 50, 1'b1);
        // boxes touching only at an edge are all kept
        plain_row(0, 0, 10, 10, 1'b0);
        plain_row(10, 0, 10, 10, 1'b0);
        plain_row(0, 10, 10, 10, 1'b1);
        // equal bottom edges, far apart
        plain_row(-500, -500, 20, 30, 1'b0);
        plain_row(500, -510, 20, 40, 1'b1);
        // zero-area boxes at the same spot are never suppressed
        plain_row(5, 5, 0, 0, 1'b0);
        plain_row(5, 5, 0, 0, 1'b1);
        // partial overlaps, both above the threshold
        plain_row(0, 0, 100, 100, 1'b0);
        plain_row(90, 0, 100, 100, 1'b0);
        plain_row(50, 50, 100, 100, 1'b1);
        // coordinate extremes with the largest sizes
        plain_row(2047, -2048, 2047, 2047, 1'b0);
        plain_row(2047, -2048, 2047, 2047, 1'b0);
        plain_row(-2048, 2047, 2047, 2047, 1'b1);

        // Hold reset, then release it
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_box(directed_rows[i].b, directed_rows[i].last, directed_rows[i].typed,
                     directed_rows[i].want);
        drain();

        // Random sets, one threshold per phase
        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 0)
                thr = '0;
            else if (ph == 1)
                thr = '1;
            else if (ph == 2)
                thr = bnms_pkg::THR_W'(32768);
            else
                thr = bnms_pkg::THR_W'($urandom_range(0, 65535));
            write_threshold(thr);
            calm = (ph == 3);
            sent = 0;
            while (sent < PHASE_BOXES)
            begin
                if (sent == 0 && ph == 2)
                    n = bnms_pkg::BOX_MAX + 1;
                else if (sent == 0 && ph == 3)
                    n = bnms_pkg::BOX_MAX;
                else if (sent == 0 && (ph == 4 || ph == 6))
                    n = $urandom_range(bnms_pkg::BOX_MAX + 2, bnms_pkg::BOX_MAX + 8);
                else if ($urandom_range(0, 7) == 0)
                    n = $urandom_range(9, 20);
                else
                    n = $urandom_range(1, 8);
                send_set(n);
                sent += n;
            end
            drain();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
